### rtl/core/binary_heap_priority_queue_defines.svh
// Assertion macros for the binary heap priority queue.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define BHPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BHPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define BHPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
`timescale 1ns / 1ps
package bhpq_pkg;
   localparam int HEAP_DEPTH_DEF = 1024;
   localparam logic [2:0] FUNC_INSERT  = 3'd0;
   localparam logic [2:0] FUNC_EXTRACT = 3'd1;
   localparam logic [2:0] FUNC_PEEK    = 3'd2;
   localparam logic [2:0] FUNC_SEARCH  = 3'd3;
   localparam logic [2:0] FUNC_REMOVE  = 3'd4;
   localparam logic [2:0] FUNC_UPDATE  = 3'd5;
   localparam logic [2:0] FUNC_CLEAR   = 3'd6;
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_value;
      logic [9:0]  found_index;
   } rsp_type;

   // strict: a belongs above b
   function automatic logic better(input logic order, input logic [31:0] a,
                                   input logic [31:0] b);
      better = order ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
   endfunction
endpackage

### rtl/core/bhpq_ram.sv
// Single-port heap storage with a registered read.
`timescale 1ns / 1ps
module bhpq_ram #(
   parameter int DEPTH = bhpq_pkg::HEAP_DEPTH_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [31:0]   wdata,
   output logic [31:0]   rdata
);
   logic [31:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

### rtl/core/binary_heap_priority_queue.sv
// Top level: binary heap priority queue controller around one heap RAM.
//
// One operation per start beat; busy stays high through the single result beat
// on rsp_valid, which the receiver cannot stall. Operations are paced by the one
// RAM port, one access per cycle. From the start beat to the result beat: peek
// reads the root, insert writes at the end and moves up, extract/remove/update
// move the last entry (or the new value) into place and move it down or up,
// and search and the match scan of remove/update read one entry at a time (up
// to fill count). Clear zeroes the entry count. No clearing pass after reset.
`timescale 1ns / 1ps
module binary_heap_priority_queue #(
   parameter int HEAP_DEPTH = bhpq_pkg::HEAP_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic signed [31:0] req_key_value,
   input  logic signed [31:0] req_replacement_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic signed [31:0] rsp_result_value,
   output logic [9:0]  rsp_found_index,
   output logic [10:0] rsp_entry_count
);
   import bhpq_pkg::*;
   `include "binary_heap_priority_queue_defines.svh"

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2,
      S_UPRD = 4'd3, S_UPCMP = 4'd4, S_DNRD = 4'd5, S_DNL = 4'd6,
      S_DNR = 4'd7, S_DNCMP = 4'd8, S_SWAPW = 4'd9, S_DONE = 4'd10,
      S_LASTRD = 4'd11, S_LASTW = 4'd12, S_FIXRD = 4'd13, S_ROOTRD = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic        order_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]  func_ff, func_in;
   logic [31:0] key_ff, key_in, repl_ff, repl_in;
   logic [AW:0] pos_ff, pos_in;       // current node
   logic [AW:0] oth_ff, oth_in;       // parent/child partner
   logic [31:0] cur_ff, cur_in;       // value held at pos
   logic [31:0] oth_v_ff, oth_v_in;   // value of partner
   logic        dn_ff, dn_in;         // direction after swap
   logic        scan_hit_ff, scan_hit_in;
   rsp_type     rsp_ff, rsp_in;
   logic        valid_ff, valid_in;

   logic          we;
   logic [AW-1:0] addr;
   logic [31:0]   wdata, rdata;

   bhpq_ram #(.DEPTH(HEAP_DEPTH), .AW(AW)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   logic [AW:0] cnt_x, parent, lch, rch;
   assign cnt_x  = (AW + 1)'(count_ff);
   assign parent = (pos_ff - 1'b1) >> 1;
   assign lch    = {pos_ff[AW-1:0], 1'b1};
   assign rch    = lch + 1'b1;

   always_comb begin
      state_in = state_ff; count_in = count_ff; func_in = func_ff;
      key_in = key_ff; repl_in = repl_ff; pos_in = pos_ff; oth_in = oth_ff;
      cur_in = cur_ff; oth_v_in = oth_v_ff; dn_in = dn_ff;
      scan_hit_in = scan_hit_ff; rsp_in = rsp_ff; valid_in = 1'b0;
      we = 1'b0; addr = pos_ff[AW-1:0]; wdata = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !valid_ff) begin
               func_in = req_func; key_in = req_key_value;
               repl_in = req_replacement_value;
               rsp_in = '0; pos_in = '0; scan_hit_in = 1'b0;
               state_in = S_DONE;
               case (req_func) inside
                  FUNC_INSERT: begin
                     if (cnt_x >= (AW + 1)'(HEAP_DEPTH)) rsp_in.status = ST_FULL;
                     else begin
                        we = 1'b1; addr = cnt_x[AW-1:0]; wdata = req_key_value;
                        pos_in = cnt_x; cur_in = req_key_value;
                        count_in = count_ff + 1'b1; state_in = S_UPRD;
                     end
                  end
                  FUNC_EXTRACT, FUNC_PEEK: begin
                     if (count_ff == '0) rsp_in.status = ST_EMPTY;
                     else begin addr = '0; state_in = S_ROOTRD; end
                  end
                  FUNC_SEARCH, FUNC_REMOVE, FUNC_UPDATE: begin
                     if (count_ff == '0) rsp_in.status = ST_NOT_FOUND;
                     else begin addr = '0; state_in = S_SCAN; end
                  end
                  FUNC_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_ROOTRD: begin
            // rdata = root
            rsp_in.result_value = rdata;
            if (func_ff == FUNC_PEEK) state_in = S_DONE;
            else begin
               pos_in = '0; addr = AW'(cnt_x - 1'b1); state_in = S_LASTRD;
            end
         end
         S_SCAN: begin
            // rdata = entry at pos
            if (rdata == key_ff) begin
               cur_in = rdata; state_in = S_SCANW;
            end else if (pos_ff + 1'b1 >= cnt_x) begin
               rsp_in.status = ST_NOT_FOUND; state_in = S_DONE;
            end else begin
               pos_in = pos_ff + 1'b1; addr = AW'(pos_ff + 1'b1);
            end
         end
         S_SCANW: begin
            unique case (func_ff)
               FUNC_SEARCH: begin
                  rsp_in.found_index = 10'(pos_ff); state_in = S_DONE;
               end
               FUNC_UPDATE: begin
                  // write the new value here, read the parent next cycle
                  we = 1'b1; wdata = repl_ff; cur_in = repl_ff;
                  state_in = S_LASTW;
               end
               default: begin
                  addr = AW'(cnt_x - 1'b1); state_in = S_LASTRD;
               end
            endcase
         end
         S_LASTRD: begin
            // rdata = last entry; drop last, and move it into pos unless pos is last
            count_in = count_ff - 1'b1;
            if (pos_ff >= cnt_x - 1'b1) state_in = S_DONE;
            else begin
               we = 1'b1; wdata = rdata; cur_in = rdata; state_in = S_LASTW;
            end
         end
         S_LASTW: begin
            oth_in = parent; addr = AW'(parent); state_in = S_FIXRD;
         end
         S_FIXRD: begin
            // rdata = parent (if pos > 0); pick direction, once moving up stay up
            if (pos_ff != '0 && better(order_ff, cur_ff, rdata)) begin
               oth_v_in = rdata; dn_in = 1'b0; state_in = S_UPCMP;
               scan_hit_in = 1'b1;
            end else begin
               state_in = scan_hit_ff ? S_DONE : S_DNRD;
            end
         end
         S_UPRD: begin
            if (pos_ff == '0) state_in = S_DONE;
            else begin
               oth_in = parent; addr = AW'(parent); state_in = S_FIXRD;
            end
         end
         S_UPCMP: begin
            // swap pos with parent: write cur at parent, parent val at pos
            we = 1'b1; addr = pos_ff[AW-1:0]; wdata = oth_v_ff;
            dn_in = 1'b0; state_in = S_SWAPW;
         end
         S_SWAPW: begin
            we = 1'b1; addr = oth_ff[AW-1:0]; wdata = cur_ff;
            pos_in = oth_ff;
            state_in = dn_ff ? S_DNRD : S_UPRD;
         end
         S_DNRD: begin
            oth_in = pos_ff; oth_v_in = cur_ff;
            if (lch < cnt_x) begin addr = AW'(lch); state_in = S_DNL; end
            else state_in = S_DONE;
         end
         S_DNL: begin
            if (better(order_ff, rdata, oth_v_ff)) begin
               oth_in = lch; oth_v_in = rdata;
            end
            if (rch < cnt_x) begin addr = AW'(rch); state_in = S_DNR; end
            else state_in = S_DNCMP;
         end
         S_DNR: begin
            if (better(order_ff, rdata, oth_v_ff)) begin
               oth_in = rch; oth_v_in = rdata;
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (oth_ff == pos_ff) state_in = S_DONE;
            else begin
               we = 1'b1; addr = pos_ff[AW-1:0]; wdata = oth_v_ff;
               dn_in = 1'b1; state_in = S_SWAPW;
            end
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; order_ff <= 1'b0; count_ff <= '0; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; valid_ff <= valid_in;
         if (csr_we) order_ff <= csr_wdata;
      end
      func_ff <= func_in; key_ff <= key_in; repl_ff <= repl_in;
      pos_ff <= pos_in; oth_ff <= oth_in; cur_ff <= cur_in;
      oth_v_ff <= oth_v_in; dn_ff <= dn_in; scan_hit_ff <= scan_hit_in;
      rsp_ff <= rsp_in;
   end

   assign busy             = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_result_value = rsp_ff.result_value;
   assign rsp_found_index  = rsp_ff.found_index;
   assign rsp_entry_count  = 11'(count_ff);

   `BHPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(HEAP_DEPTH))
   `BHPQ_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `BHPQ_ASSERT_NEXT(a_one_beat, clock, reset, valid_ff, !valid_ff)
   `BHPQ_ASSERT_IMP(a_we_range, clock, reset, we && state_ff != S_IDLE, (AW + 1)'(addr) < cnt_x)
endmodule
